// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the blur block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gblur_pkg.sv =====
// ----------------------------------------------------------------------------
// gblur_pkg
// Types and constants shared by the 3x3 binomial blur modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gblur_pkg;

   localparam int PIXEL_W      = 8;
   localparam int COLSUM_W     = 10;
   localparam int SUM_W        = 12;
   localparam int NORM_SHIFT   = 4;
   localparam int NUM_COLS     = 3;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [SUM_W-1:0]        ROUND_BIAS   = 12'd8;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic [PIXEL_W-1:0] px_top;
      logic [PIXEL_W-1:0] px_mid;
      logic [PIXEL_W-1:0] px_bot;
   } column_type;

   typedef enum logic [1:0] {
      COL_LEFT,
      COL_CENTRE,
      COL_RIGHT
   } col_idx_type;

endpackage

// ===== design/gblur_ram.sv =====
// ----------------------------------------------------------------------------
// gblur_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gblur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gblur_cell.sv =====
// ----------------------------------------------------------------------------
// gblur_cell
// One column of the 3x3 window: holds three pixels, passes them to its left
// neighbour on a shift and gives the vertical 1-2-1 sum of its column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gblur_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift_en,
   input  gblur_pkg::column_type               load_col,
   output gblur_pkg::column_type               held_col,
   output logic [gblur_pkg::COLSUM_W-1:0]      col_sum
);

   import gblur_pkg::*;

   column_type held_col_ff;
   column_type held_col_in;

   always_comb begin
      held_col_in = shift_en ? load_col : held_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_col_ff <= '0;
      end else begin
         held_col_ff <= held_col_in;
      end
   end

   assign held_col = held_col_ff;
   assign col_sum  = COLSUM_W'(held_col_ff.px_top)
                   + (COLSUM_W'(held_col_ff.px_mid) << 1)
                   + COLSUM_W'(held_col_ff.px_bot);

endmodule

// ===== design/gaussian_blur_3x3_clamped.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_clamped: 3x3 binomial blur of a raster stream of grey words.
// Path: the input word that completes a result passes the first, second and third stage registers.
// Throughput: one word per cycle while the sink takes results, set by the line store read and window shift.
// Reset: synchronous; 640 x 480 frame, counters, window and pipeline cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_blur_3x3_clamped #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gblur_pkg::PIXEL_W-1:0]       req_tdata,   // pixel
   input  logic                                req_tuser,   // command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gblur_pkg::PIXEL_W-1:0]       rsp_tdata,   // blurred
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [gblur_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gblur_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   import gblur_pkg::*;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);
   localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
   localparam int EW_W      = $clog2(MAX_WIDTH + 1);
   localparam int EH_W      = $clog2(MAX_HEIGHT + 1);

   typedef struct packed {
      logic               shift;
      logic               wr;
      logic               top_mid;
      logic               bot_mid;
      logic               emits;
      col_idx_type        sel_a;
      col_idx_type        sel_b;
      col_idx_type        sel_c;
      logic               frame_end;
      logic [COL_W-1:0]   addr;
      logic [PIXEL_W-1:0] px;
   } s1_type;

   typedef struct packed {
      col_idx_type sel_a;
      col_idx_type sel_b;
      col_idx_type sel_c;
      logic        frame_end;
   } s2_type;

   function automatic logic [COLSUM_W-1:0] pick_col(
      input col_idx_type         sel,
      input logic [COLSUM_W-1:0] left_sum,
      input logic [COLSUM_W-1:0] centre_sum,
      input logic [COLSUM_W-1:0] right_sum
   );
      logic [COLSUM_W-1:0] res;
      unique case (sel)
         COL_LEFT:   res = left_sum;
         COL_CENTRE: res = centre_sum;
         COL_RIGHT:  res = right_sum;
         default:    res = '0;
      endcase
      return res;
   endfunction

   logic [WIDTH_REG_W-1:0]  width_ff,  width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [EW_W-1:0]         eff_w;
   logic [EH_W-1:0]         eff_h;
   logic [ROW_W-1:0]        h_r;

   logic [COL_W-1:0]     in_col_ff,  in_col_in;
   logic [ROW_W-1:0]     in_row_ff,  in_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic [PIXEL_W-1:0] rsp_blur_ff, rsp_blur_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               byp_hit_ff, byp_hit_in;
   logic [PIXEL_W-1:0] byp_lower_ff, byp_lower_in;
   logic [PIXEL_W-1:0] byp_upper_ff, byp_upper_in;

   logic out_free, s2_free, s2_adv, s1_free, s1_adv, accept;
   logic is_drain, in_frame, ignore, col_zero, row_ge1, row_ge2, shift;
   logic emit_last, emit_mid, emits, last_col, wide, left_edge;
   logic out_last, out_col_last;

   logic [PIXEL_W-1:0] upper_rd, lower_rd, lower_v, upper_v;
   column_type         new_col;
   logic               shift_en, ram_wr;

   column_type          held [NUM_COLS];
   logic [COLSUM_W-1:0] col_sum [NUM_COLS];
   logic [SUM_W-1:0]    total;

   // Effective frame size.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = EW_W'(MAX_WIDTH);
      end else begin
         eff_w = EW_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = EH_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = EH_W'(MAX_HEIGHT);
      end else begin
         eff_h = EH_W'(height_ff);
      end
      h_r = ROW_W'(eff_h);
   end

   // Flow control.
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      s2_adv     = s2_valid_ff && out_free;
      s2_free    = !s2_valid_ff || out_free;
      s1_adv     = s1_valid_ff && s2_free;
      s1_free    = !s1_valid_ff || s2_free;
      accept     = req_tvalid && s1_free;
      req_tready = s1_free;
   end

   // Decode of the incoming word against the raster position.
   always_comb begin
      is_drain     = (req_tuser == CMD_DRAIN);
      in_frame     = in_row_ff < h_r;
      ignore       = in_frame && is_drain;
      col_zero     = (in_col_ff == '0);
      row_ge1      = (in_row_ff != '0);
      row_ge2      = (in_row_ff >= ROW_W'(2));
      shift        = (in_row_ff <= h_r);
      emit_last    = col_zero && row_ge2;
      emit_mid     = shift && !col_zero && row_ge1;
      emits        = emit_last || emit_mid;
      last_col     = (EW_W'(in_col_ff) + EW_W'(1)) == eff_w;
      wide         = (eff_w >= EW_W'(2));
      left_edge    = (in_col_ff < COL_W'(2));
      out_col_last = (EW_W'(out_col_ff) + EW_W'(1)) == eff_w;
      out_last     = out_col_last && ((EH_W'(out_row_ff) + EH_W'(1)) == eff_h);
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wr_data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wr_data[HEIGHT_REG_W-1:0];
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept && !ignore) begin
         if (!shift) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (last_col) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (emits) begin
               priority if (out_last) begin
                  out_col_in = '0;
                  out_row_in = '0;
               end else if (out_col_last) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + OUT_ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   // First stage: control for the word, line store read issued.
   always_comb begin
      s1_in           = s1_ff;
      s1_valid_in     = s1_free ? (accept && !ignore) : s1_valid_ff;
      byp_hit_in      = byp_hit_ff;
      byp_lower_in    = byp_lower_ff;
      byp_upper_in    = byp_upper_ff;
      if (accept) begin
         s1_in.shift     = shift;
         s1_in.wr        = in_frame;
         s1_in.top_mid   = !row_ge2;
         s1_in.bot_mid   = !in_frame;
         s1_in.emits     = emits;
         s1_in.frame_end = out_last;
         s1_in.addr      = in_col_ff;
         s1_in.px        = req_tdata;
         priority if (emit_mid) begin
            s1_in.sel_a = left_edge ? COL_CENTRE : COL_LEFT;
            s1_in.sel_b = COL_CENTRE;
            s1_in.sel_c = COL_RIGHT;
         end else if (shift) begin
            s1_in.sel_a = wide ? COL_LEFT : COL_CENTRE;
            s1_in.sel_b = COL_CENTRE;
            s1_in.sel_c = COL_CENTRE;
         end else begin
            s1_in.sel_a = wide ? COL_CENTRE : COL_RIGHT;
            s1_in.sel_b = COL_RIGHT;
            s1_in.sel_c = COL_RIGHT;
         end
         byp_hit_in   = s1_valid_ff && s1_ff.wr && (s1_ff.addr == in_col_ff);
         byp_lower_in = s1_ff.px;
         byp_upper_in = lower_v;
      end
   end

   // Second stage: new window column, line store write-back.
   always_comb begin
      lower_v        = byp_hit_ff ? byp_lower_ff : lower_rd;
      upper_v        = byp_hit_ff ? byp_upper_ff : upper_rd;
      new_col.px_mid = lower_v;
      new_col.px_top = s1_ff.top_mid ? lower_v : upper_v;
      new_col.px_bot = s1_ff.bot_mid ? lower_v : s1_ff.px;
      shift_en       = s1_adv && s1_ff.shift;
      ram_wr         = s1_adv && s1_ff.wr;
   end

   gblur_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (s1_ff.addr),
      .wr_data (lower_v),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (upper_rd)
   );

   gblur_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_lower (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (s1_ff.addr),
      .wr_data (s1_ff.px),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (lower_rd)
   );

   // Window: the rightmost cell takes the new column, each cell feeds its left neighbour.
   for (genvar i = 0; i < NUM_COLS; i++) begin : g_cell
      if (i == NUM_COLS - 1) begin : g_feed_new
         gblur_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .load_col (new_col),
            .held_col (held[i]),
            .col_sum  (col_sum[i])
         );
      end else begin : g_feed_right
         gblur_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .load_col (held[i+1]),
            .held_col (held[i]),
            .col_sum  (col_sum[i])
         );
      end
   end

   // Third stage: horizontal 1-2-1 over the selected columns, rounding.
   always_comb begin
      s2_in       = s2_ff;
      s2_valid_in = s2_free ? (s1_adv && s1_ff.emits) : s2_valid_ff;
      if (s1_adv) begin
         s2_in.sel_a     = s1_ff.sel_a;
         s2_in.sel_b     = s1_ff.sel_b;
         s2_in.sel_c     = s1_ff.sel_c;
         s2_in.frame_end = s1_ff.frame_end;
      end
      total = SUM_W'(pick_col(s2_ff.sel_a, col_sum[0], col_sum[1], col_sum[2]))
            + (SUM_W'(pick_col(s2_ff.sel_b, col_sum[0], col_sum[1], col_sum[2])) << 1)
            + SUM_W'(pick_col(s2_ff.sel_c, col_sum[0], col_sum[1], col_sum[2]))
            + ROUND_BIAS;
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
      rsp_blur_in  = rsp_blur_ff;
      rsp_last_in  = rsp_last_ff;
      if (s2_adv) begin
         rsp_blur_in = total[SUM_W-1:NORM_SHIFT];
         rsp_last_in = s2_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_hit_ff   <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_hit_ff   <= byp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      rsp_blur_ff  <= rsp_blur_in;
      rsp_last_ff  <= rsp_last_in;
      byp_lower_ff <= byp_lower_in;
      byp_upper_ff <= byp_upper_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_blur_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/gblur_checker.sv =====
// ----------------------------------------------------------------------------
// gblur_checker
// Port-level checks of the blur block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gblur_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [gblur_pkg::PIXEL_W-1:0] rsp_tdata,
   input logic                          rsp_tlast
);

   // A result word waiting for the sink must not change.
   `ASSERT_RST(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "result word changed while stalled")

   // Reset leaves no result word pending.
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) && !reset |-> !rsp_tvalid,
      "result word present after reset")

   // With the output register empty nothing can hold the input back.
   `ASSERT_RST(a_no_false_stall, clock, reset, !rsp_tvalid |-> req_tready,
      "input stalled with empty output")

   // Reset leaves the input side open.
   `ASSERT_ALWAYS(a_reset_ready, clock, $past(reset) && !reset |-> req_tready,
      "input not ready after reset")

endmodule

bind gaussian_blur_3x3_clamped gblur_checker u_gblur_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
